[hw/rtl/mcr_pkg.sv]
// shared types and constants for the midpoint circle rasterizer
// no dependencies; imported by every rtl file of the block

package mcr_pkg;

  localparam int unsigned CoordW      = 16;  // centre coordinate width
  localparam int unsigned RadiusW     = 12;  // radius field width on the stream
  localparam int unsigned PointW      = 17;  // emitted point coordinate width
  localparam int unsigned IN_TDATA_W  = 48;  // centre_x, centre_y, radius, pad
  localparam int unsigned OUT_TDATA_W = 40;  // point_x, point_y, pad
  localparam int unsigned OUT_TUSER_W = 2;   // point_valid, circle_done

  localparam int unsigned RADIUS_BITS_DEF = 12;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned PointsPerStep = 8;

  typedef enum logic {
    KindStart   = 1'b0,
    KindAdvance = 1'b1
  } kind_e;

  // flags that travel with each step command from front to back
  typedef struct packed {
    logic no_walk;  // emit one empty result instead of eight points
    logic done;     // walk ends after this step
  } cmd_flags_t;

  localparam int unsigned FlagsW = $bits(cmd_flags_t);

endpackage

[hw/rtl/mcr_front.sv]
// front end: accepts stream items, keeps the walk state and issues step commands
// depends on mcr_pkg

module mcr_front #(
  parameter int unsigned RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF,
  parameter int unsigned CMD_W       = mcr_pkg::FlagsW + 2 * mcr_pkg::CoordW
                                       + 2 * (RADIUS_BITS + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           kind_i,
  input  logic signed [mcr_pkg::CoordW-1:0] centre_x_i,
  input  logic signed [mcr_pkg::CoordW-1:0] centre_y_i,
  input  logic [mcr_pkg::RadiusW-1:0]    radius_i,
  output logic                           push_valid_o,
  input  logic                           push_ready_i,
  output logic [CMD_W-1:0]               push_data_o
);
  import mcr_pkg::*;

  localparam int unsigned XW = RADIUS_BITS + 1;  // signed walk coordinate
  localparam int unsigned TW = RADIUS_BITS + 2;  // step increments
  localparam int unsigned EW = RADIUS_BITS + 4;  // decision error
  localparam int unsigned DW = RADIUS_BITS + 1;  // diameter

  logic signed [CoordW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [XW-1:0]     x_q, x_d, y_q, y_d;
  logic [TW-1:0]            tx_q, tx_d, ty_q, ty_d;
  logic signed [EW-1:0]     err_q, err_d;
  logic [DW-1:0]            diam_q, diam_d;
  logic                     active_q, active_d;

  logic [RADIUS_BITS-1:0]   r_in;
  logic                     accept, is_advance, has_walk;
  logic                     y_step, x_step, done;
  logic signed [EW-1:0]     err1, err2;
  logic signed [XW-1:0]     x_n, y_n;
  logic [TW-1:0]            tx_n, ty_n;
  cmd_flags_t               flags;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_advance = (kind_e'(kind_i) == KindAdvance);
  assign r_in       = RADIUS_BITS'(radius_i);
  assign has_walk   = active_q && !(x_q < y_q);

  // one midpoint step
  always_comb begin
    y_step = err_q[EW-1] || (err_q == '0);
    err1   = y_step ? err_q + $signed(EW'(ty_q)) : err_q;
    ty_n   = y_step ? ty_q + TW'(2) : ty_q;
    y_n    = y_step ? y_q + XW'(1) : y_q;
    x_step = !err1[EW-1] && (err1 != '0);
    tx_n   = x_step ? tx_q + TW'(2) : tx_q;
    err2   = x_step ? err1 + $signed(EW'(tx_n)) - $signed(EW'(diam_q)) : err1;
    x_n    = x_step ? x_q - XW'(1) : x_q;
    done   = (x_n < y_n);
  end

  always_comb begin
    cx_d     = cx_q;
    cy_d     = cy_q;
    x_d      = x_q;
    y_d      = y_q;
    tx_d     = tx_q;
    ty_d     = ty_q;
    err_d    = err_q;
    diam_d   = diam_q;
    active_d = active_q;
    if (accept) begin
      if (!is_advance) begin
        cx_d     = centre_x_i;
        cy_d     = centre_y_i;
        diam_d   = {r_in, 1'b0};
        x_d      = $signed({1'b0, r_in}) - XW'(1);
        y_d      = '0;
        tx_d     = TW'(1);
        ty_d     = TW'(1);
        err_d    = EW'(1) - $signed(EW'({r_in, 1'b0}));
        active_d = 1'b1;
      end else if (has_walk) begin
        x_d      = x_n;
        y_d      = y_n;
        tx_d     = tx_n;
        ty_d     = ty_n;
        err_d    = err2;
        active_d = !done;
      end else begin
        active_d = 1'b0;
      end
    end
  end

  assign flags.no_walk = !has_walk;
  assign flags.done    = has_walk ? done : 1'b1;

  assign push_valid_o = in_valid_i && is_advance;
  assign push_data_o  = {flags, cx_q, cy_q, x_q, y_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      x_q      <= '0;
      y_q      <= '0;
      tx_q     <= TW'(1);
      ty_q     <= TW'(1);
      err_q    <= '0;
      diam_q   <= '0;
      active_q <= 1'b0;
    end else begin
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      x_q      <= x_d;
      y_q      <= y_d;
      tx_q     <= tx_d;
      ty_q     <= ty_d;
      err_q    <= err_d;
      diam_q   <= diam_d;
      active_q <= active_d;
    end
  end

endmodule

[hw/rtl/mcr_queue.sv]
// short command queue between front and back, flip-flop storage
// depends on mcr_pkg only for the default depth; generic width and depth

module mcr_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = mcr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import mcr_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hw/rtl/mcr_back.sv]
// back end: expands each step command into mirrored points,
// one beat per cycle unless the output stalls; depends on mcr_pkg

module mcr_back #(
  parameter int unsigned RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF,
  parameter int unsigned CMD_W       = mcr_pkg::FlagsW + 2 * mcr_pkg::CoordW
                                       + 2 * (RADIUS_BITS + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  output logic                           cmd_ready_o,
  input  logic [CMD_W-1:0]               cmd_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [mcr_pkg::PointW-1:0] point_x_o,
  output logic signed [mcr_pkg::PointW-1:0] point_y_o,
  output logic                           point_valid_o,
  output logic                           last_o,
  output logic                           circle_done_o
);
  import mcr_pkg::*;

  localparam int unsigned XW   = RADIUS_BITS + 1;
  localparam int unsigned IdxW = $clog2(PointsPerStep);

  cmd_flags_t                flags;
  logic signed [CoordW-1:0]  cx, cy;
  logic signed [XW-1:0]      wx, wy, sel_a, sel_b;
  logic signed [PointW-1:0]  cx_ext, cy_ext, a_ext, b_ext, px, py;
  logic                      fire, last_point;

  logic [IdxW-1:0]           idx_q, idx_d;
  logic                      valid_q, valid_d;
  logic signed [PointW-1:0]  px_q, py_q;
  logic                      pvalid_q, last_q, done_q;

  assign {flags, cx, cy, wx, wy} = cmd_data_i;

  assign fire       = cmd_valid_i && (!valid_q || out_ready_i);
  assign last_point = flags.no_walk || (idx_q == IdxW'(PointsPerStep - 1));
  assign cmd_ready_o = fire && last_point;

  // octant order: idx[2] swaps x and y, idx[1] negates the x offset,
  // idx[0] clear negates the y offset
  always_comb begin
    sel_a  = idx_q[2] ? wy : wx;
    sel_b  = idx_q[2] ? wx : wy;
    cx_ext = PointW'(cx);
    cy_ext = PointW'(cy);
    a_ext  = PointW'(sel_a);
    b_ext  = PointW'(sel_b);
    px     = idx_q[1] ? cx_ext - a_ext : cx_ext + a_ext;
    py     = idx_q[0] ? cy_ext + b_ext : cy_ext - b_ext;
  end

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (fire) begin
      valid_d = 1'b1;
      idx_d   = last_point ? '0 : idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      px_q     <= flags.no_walk ? '0 : px;
      py_q     <= flags.no_walk ? '0 : py;
      pvalid_q <= !flags.no_walk;
      last_q   <= last_point;
      done_q   <= last_point && flags.done;
    end
  end

  assign out_valid_o   = valid_q;
  assign point_x_o     = px_q;
  assign point_y_o     = py_q;
  assign point_valid_o = pvalid_q;
  assign last_o        = last_q;
  assign circle_done_o = done_q;

  a_empty_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !pvalid_q |-> last_q && done_q)
    else $error("empty result must close the step and the walk");

  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && done_q |-> last_q)
    else $error("circle_done set on a beat that is not last");

  a_mid_step_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != '0 |-> cmd_valid_i && !flags.no_walk)
    else $error("point index advanced without a point command at the head");

  a_idx_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !last_point |=> idx_q == $past(idx_q) + IdxW'(1))
    else $error("point index did not advance by one");

endmodule

[hw/rtl/midpoint_circle_rasterizer_core.sv]
// top level of the midpoint circle rasterizer: front, command queue, back
// depends on mcr_pkg, mcr_front, mcr_queue, mcr_back
//
// channel  dir  tdata (low bit up)                          tuser / tlast
// s_axis   in   centre_x[15:0] centre_y[31:16] radius[43:32]  tuser[0] kind
// m_axis   out  point_x[16:0] point_y[33:17]                 tuser[0] point_valid,
//                                                            tuser[1] circle_done,
//                                                            tlast last
//
// a start beat is accepted and gives no result
// an advance beat with an active walk gives 8 result beats, one per cycle from the
// back-end point emitter while m_axis is not stalled; an advance with no walk
// gives a single beat
// the front takes a beat every cycle while the QUEUE_DEPTH-entry command queue has room
// m_axis stalls hold the output register; reset clears the walk and the queue

module midpoint_circle_rasterizer_core #(
  parameter int unsigned RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = mcr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [mcr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // centre_x, centre_y, radius
  input  logic [0:0]                         s_axis_tuser,   // kind
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [mcr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // point_x, point_y
  output logic [mcr_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,   // point_valid, circle_done
  output logic                               m_axis_tlast
);
  import mcr_pkg::*;

  localparam int unsigned CMD_W = FlagsW + 2 * CoordW + 2 * (RADIUS_BITS + 1);

  logic                     push_valid, push_ready, pop_valid, pop_ready;
  logic [CMD_W-1:0]         push_data, pop_data;
  logic signed [PointW-1:0] point_x, point_y;
  logic                     point_valid, circle_done;

  mcr_front #(
    .RADIUS_BITS (RADIUS_BITS),
    .CMD_W       (CMD_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .kind_i       (s_axis_tuser[0]),
    .centre_x_i   ($signed(s_axis_tdata[CoordW-1:0])),
    .centre_y_i   ($signed(s_axis_tdata[2*CoordW-1:CoordW])),
    .radius_i     (s_axis_tdata[2*CoordW+RadiusW-1:2*CoordW]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  mcr_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  mcr_back #(
    .RADIUS_BITS (RADIUS_BITS),
    .CMD_W       (CMD_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (pop_valid),
    .cmd_ready_o   (pop_ready),
    .cmd_data_i    (pop_data),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .point_x_o     (point_x),
    .point_y_o     (point_y),
    .point_valid_o (point_valid),
    .last_o        (m_axis_tlast),
    .circle_done_o (circle_done)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - 2 * PointW){1'b0}}, point_y, point_x};
  assign m_axis_tuser = {circle_done, point_valid};

endmodule
